// File: hw/rtl/source_byte_tokenizer_defines.svh
// Assertion macros shared by the tokenizer RTL.
// Depends on nothing; included by the top level of the tokenizer.
`ifndef SOURCE_BYTE_TOKENIZER_DEFINES_SVH
`define SOURCE_BYTE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/sbt_pkg.sv
// Types, constants and helper functions of the source byte tokenizer.
// Depends on nothing; used by every tokenizer module.
package sbt_pkg;

	localparam int CNT_W = 16;

	localparam int Q_DEPTH = 4;
	localparam int Q_IDX_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam int R_DEPTH = 4;
	localparam int R_IDX_W = $clog2(R_DEPTH);
	localparam int R_CNT_W = $clog2(R_DEPTH + 1);

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_END  = 1'b1;

	localparam logic [4:0] KIND_EOF     = 5'd0;
	localparam logic [4:0] KIND_NEWLINE = 5'd1;
	localparam logic [4:0] KIND_IDENT   = 5'd2;
	localparam logic [4:0] KIND_CONST   = 5'd3;
	localparam logic [4:0] KIND_VAR     = 5'd4;
	localparam logic [4:0] KIND_AUTO    = 5'd5;
	localparam logic [4:0] KIND_INT     = 5'd6;
	localparam logic [4:0] KIND_FLOAT   = 5'd7;
	localparam logic [4:0] KIND_PUNCT0  = 5'd8;
	localparam logic [4:0] KIND_SEMI    = 5'd17;
	localparam logic [4:0] KIND_BADCHAR = 5'd19;
	localparam logic [4:0] KIND_BADNUM  = 5'd20;
	localparam logic [4:0] KIND_NONE    = 5'd31;

	localparam logic [7:0] BYTE_TAB   = 8'h09;
	localparam logic [7:0] BYTE_LF    = 8'h0A;
	localparam logic [7:0] BYTE_CR    = 8'h0D;
	localparam logic [7:0] BYTE_SPACE = 8'h20;
	localparam logic [7:0] BYTE_DOT   = 8'h2E;
	localparam logic [7:0] BYTE_US    = 8'h5F;

	localparam int PUNCT_N = 11;
	localparam logic [7:0] PUNCT_CHARS [PUNCT_N] = '{
		8'h28, 8'h29, 8'h7B, 8'h7D, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h3B, 8'h3A
	};

	// Keywords packed with their first character in the low byte.
	localparam logic [39:0] KW_CONST = 40'h74_73_6E_6F_63;
	localparam logic [39:0] KW_VAR   = 40'h00_00_72_61_76;
	localparam logic [39:0] KW_AUTO  = 40'h00_6F_74_75_61;
	localparam logic [39:0] KW_INT   = 40'h00_00_74_6E_69;
	localparam logic [39:0] KW_FLOAT = 40'h74_61_6F_6C_66;

	typedef struct packed {
		logic       cmd;
		logic [7:0] byte_value;
	} src_word_t;

	typedef struct packed {
		logic [4:0]  token_kind;
		logic [15:0] first_line;
		logic [15:0] start_column;
		logic [15:0] byte_length;
		logic        errors_seen;
		logic        last_of_run;
	} tok_word_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] byte_value;
		logic       blank;
		logic       lf;
		logic       cr;
		logic       alpha;
		logic       digit;
		logic       dot;
		logic       cont;
		logic       punct;
		logic [4:0] punct_kind;
		logic [1:0] lead_cnt;
	} cls_word_t;

	typedef struct packed {
		logic      v0;
		logic      v1;
		tok_word_t w0;
		tok_word_t w1;
	} res_wr_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (&v) ? v : v + CNT_W'(1);
	endfunction

	function automatic logic [15:0] clamp16(input logic [CNT_W-1:0] v);
		if (v > CNT_W'(32'h0000_FFFF))
			return 16'hFFFF;
		return 16'(v);
	endfunction

endpackage

// File: hw/rtl/sbt_front.sv
// Front end of the tokenizer: classifies each incoming source word.
// Depends on sbt_pkg.
module sbt_front (
	input  sbt_pkg::src_word_t source,
	output sbt_pkg::cls_word_t cls
);
	import sbt_pkg::*;

	logic [7:0] b;

	assign b = source.byte_value;

	always_comb begin
		cls = '0;
		cls.cmd = source.cmd;
		cls.byte_value = b;
		cls.blank = (b == BYTE_SPACE) || (b == BYTE_TAB);
		cls.lf = (b == BYTE_LF);
		cls.cr = (b == BYTE_CR);
		cls.alpha = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || (b == BYTE_US);
		cls.digit = (b >= 8'h30 && b <= 8'h39);
		cls.dot = (b == BYTE_DOT);
		cls.cont = (b[7:6] == 2'b10);
		for (int i = 0; i < PUNCT_N; i++) begin
			if (b == PUNCT_CHARS[i]) begin
				cls.punct = 1'b1;
				cls.punct_kind = KIND_PUNCT0 + 5'(i);
			end
		end
		priority if (b[7:5] == 3'b110) begin
			cls.lead_cnt = 2'd1;
		end else if (b[7:4] == 4'b1110) begin
			cls.lead_cnt = 2'd2;
		end else if (b[7:3] == 5'b11110) begin
			cls.lead_cnt = 2'd3;
		end else begin
			cls.lead_cnt = 2'd0;
		end
	end

endmodule

// File: hw/rtl/sbt_queue.sv
// Short queue of classified words between the front and back ends.
// Depends on sbt_pkg.
module sbt_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  sbt_pkg::cls_word_t wr_data,
	output logic               valid,
	input  logic               pop,
	output sbt_pkg::cls_word_t rd_data
);
	import sbt_pkg::*;

	cls_word_t          mem_q [Q_DEPTH];
	logic [Q_IDX_W-1:0] wp_q;
	logic [Q_IDX_W-1:0] rp_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               push_ok;
	logic               pop_ok;

	assign full = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign valid = (cnt_q != '0);
	assign push_ok = push && !full;
	assign pop_ok = pop && valid;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wp_q <= wp_q + Q_IDX_W'(1);
			end
			if (pop_ok) begin
				rp_q <= rp_q + Q_IDX_W'(1);
			end
			cnt_q <= cnt_q + Q_CNT_W'(push_ok) - Q_CNT_W'(pop_ok);
		end
	end

endmodule

// File: hw/rtl/sbt_back.sv
// Back end of the tokenizer: scanner state, token building and repeat filtering.
// Depends on sbt_pkg; feeds the result queue with up to two words per cycle.
module sbt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  sbt_pkg::cls_word_t c,
	output logic               q_pop,
	input  logic               room,
	output sbt_pkg::res_wr_t   res_wr
);
	import sbt_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_IDENT,
		PH_INT,
		PH_DOT,
		PH_FRAC,
		PH_CR
	} phase_t;

	phase_t           phase_q, n_phase;
	logic [CNT_W-1:0] line_q, n_line;
	logic [CNT_W-1:0] col_q, n_col;
	logic [CNT_W-1:0] tl_q, n_tl;
	logic [CNT_W-1:0] tc_q, n_tc;
	logic [CNT_W-1:0] len_q, n_len;
	logic [39:0]      kb_q, n_kb;
	logic [1:0]       swallow_q, n_swallow;
	logic [4:0]       last_q, n_last;
	logic             err_q, n_err;

	logic             take;
	logic             grow;
	logic             a_v, a_keep, a_iserr;
	logic [4:0]       a_k;
	logic [CNT_W-1:0] a_len;
	logic             b_v, b_keep, b_iserr, b_err, b_eof;
	logic [4:0]       b_k;
	logic [CNT_W-1:0] b_len;
	logic [4:0]       last1;
	tok_word_t        tok_a, tok_b;

	function automatic logic [4:0] flush_kind(input phase_t ph, input logic [CNT_W-1:0] len,
			input logic [39:0] kb);
		logic [4:0] k;
		k = KIND_NONE;
		unique case (ph)
			PH_IDENT: begin
				priority if (len == CNT_W'(5) && kb == KW_CONST) begin
					k = KIND_CONST;
				end else if (len == CNT_W'(3) && kb == KW_VAR) begin
					k = KIND_VAR;
				end else if (len == CNT_W'(4) && kb == KW_AUTO) begin
					k = KIND_AUTO;
				end else if (len == CNT_W'(3) && kb == KW_INT) begin
					k = KIND_AUTO;
				end else if (len == CNT_W'(5) && kb == KW_FLOAT) begin
					k = KIND_AUTO;
				end else begin
					k = KIND_IDENT;
				end
			end
			PH_INT: k = KIND_INT;
			PH_DOT: k = KIND_BADNUM;
			PH_FRAC: k = KIND_FLOAT;
			PH_CR: k = KIND_NEWLINE;
			default: k = KIND_NONE;
		endcase
		return k;
	endfunction

	assign take = q_valid && room;
	assign q_pop = take;

	always_comb begin
		unique case (phase_q)
			PH_IDENT: grow = c.alpha || c.digit || c.cont;
			PH_INT: grow = c.digit || c.dot;
			PH_DOT, PH_FRAC: grow = c.digit;
			default: grow = 1'b0;
		endcase
	end

	always_comb begin
		n_phase = phase_q;
		n_line = line_q;
		n_col = col_q;
		n_tl = tl_q;
		n_tc = tc_q;
		n_len = len_q;
		n_kb = kb_q;
		n_swallow = swallow_q;
		a_v = 1'b0;
		a_k = flush_kind(phase_q, len_q, kb_q);
		a_len = len_q;
		b_v = 1'b0;
		b_k = KIND_BADCHAR;
		b_len = CNT_W'(1);
		b_eof = 1'b0;

		if (take) begin
			if (c.cmd == CMD_END) begin
				a_v = (phase_q != PH_IDLE);
				b_v = 1'b1;
				b_k = KIND_EOF;
				b_len = '0;
				b_eof = 1'b1;
			end else if (swallow_q != 2'd0) begin
				n_swallow = swallow_q - 2'd1;
			end else if (grow) begin
				for (int i = 0; i < 5; i++) begin
					if (len_q == CNT_W'(i)) begin
						n_kb[8*i +: 8] = c.byte_value;
					end
				end
				n_len = sat_inc(len_q);
				n_col = sat_inc(col_q);
				if (phase_q == PH_INT) begin
					n_phase = c.dot ? PH_DOT : PH_INT;
				end else if (phase_q == PH_DOT) begin
					n_phase = PH_FRAC;
				end
			end else if (phase_q == PH_CR && c.lf) begin
				a_v = 1'b1;
				a_k = KIND_NEWLINE;
				a_len = CNT_W'(2);
				n_phase = PH_IDLE;
			end else begin
				a_v = (phase_q != PH_IDLE);
				n_phase = PH_IDLE;
				priority if (c.blank) begin
					n_col = sat_inc(col_q);
				end else if (c.lf) begin
					b_v = 1'b1;
					b_k = KIND_NEWLINE;
					n_line = sat_inc(line_q);
					n_col = CNT_W'(1);
				end else if (c.cr) begin
					n_tl = line_q;
					n_tc = col_q;
					n_len = CNT_W'(1);
					n_kb = '0;
					n_line = sat_inc(line_q);
					n_col = CNT_W'(1);
					n_phase = PH_CR;
				end else if (c.alpha) begin
					n_tl = line_q;
					n_tc = col_q;
					n_len = CNT_W'(1);
					n_kb = {32'd0, c.byte_value};
					n_col = sat_inc(col_q);
					n_phase = PH_IDENT;
				end else if (c.digit) begin
					n_tl = line_q;
					n_tc = col_q;
					n_len = CNT_W'(1);
					n_kb = '0;
					n_col = sat_inc(col_q);
					n_phase = PH_INT;
				end else if (c.punct) begin
					b_v = 1'b1;
					b_k = c.punct_kind;
					n_col = sat_inc(col_q);
				end else begin
					b_v = 1'b1;
					b_k = KIND_BADCHAR;
					n_col = sat_inc(col_q);
					n_swallow = c.lead_cnt;
				end
			end
		end

		// A newline or semicolon that repeats the last kept token other than an error token is dropped.
		a_iserr = (a_k == KIND_BADCHAR) || (a_k == KIND_BADNUM);
		a_keep = a_v && !(((a_k == KIND_NEWLINE) || (a_k == KIND_SEMI)) && (a_k == last_q));
		last1 = (a_keep && !a_iserr) ? a_k : last_q;
		b_iserr = (b_k == KIND_BADCHAR) || (b_k == KIND_BADNUM);
		b_keep = b_v && !(((b_k == KIND_NEWLINE) || (b_k == KIND_SEMI)) && (b_k == last1));
		n_last = (b_keep && !b_iserr && !b_eof) ? b_k : last1;
		n_err = err_q || (a_keep && a_iserr) || (b_keep && b_iserr);
		b_err = b_eof && (err_q || (a_keep && a_iserr));

		if (b_eof) begin
			n_phase = PH_IDLE;
			n_line = CNT_W'(1);
			n_col = CNT_W'(1);
			n_tl = CNT_W'(1);
			n_tc = CNT_W'(1);
			n_len = '0;
			n_kb = '0;
			n_swallow = 2'd0;
			n_last = KIND_NONE;
			n_err = 1'b0;
		end
	end

	always_comb begin
		tok_a.token_kind = a_k;
		tok_a.first_line = clamp16(tl_q);
		tok_a.start_column = clamp16(tc_q);
		tok_a.byte_length = clamp16(a_len);
		tok_a.errors_seen = 1'b0;
		tok_a.last_of_run = !b_keep;

		tok_b.token_kind = b_k;
		tok_b.first_line = clamp16(line_q);
		tok_b.start_column = clamp16(col_q);
		tok_b.byte_length = clamp16(b_len);
		tok_b.errors_seen = b_err;
		tok_b.last_of_run = 1'b1;

		if (a_keep) begin
			res_wr.v0 = 1'b1;
			res_wr.v1 = b_keep;
			res_wr.w0 = tok_a;
			res_wr.w1 = tok_b;
		end else begin
			res_wr.v0 = b_keep;
			res_wr.v1 = 1'b0;
			res_wr.w0 = tok_b;
			res_wr.w1 = tok_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			line_q <= CNT_W'(1);
			col_q <= CNT_W'(1);
			tl_q <= CNT_W'(1);
			tc_q <= CNT_W'(1);
			len_q <= '0;
			kb_q <= '0;
			swallow_q <= 2'd0;
			last_q <= KIND_NONE;
			err_q <= 1'b0;
		end else begin
			phase_q <= n_phase;
			line_q <= n_line;
			col_q <= n_col;
			tl_q <= n_tl;
			tc_q <= n_tc;
			len_q <= n_len;
			kb_q <= n_kb;
			swallow_q <= n_swallow;
			last_q <= n_last;
			err_q <= n_err;
		end
	end

endmodule

// File: hw/rtl/sbt_out_fifo.sv
// Result queue: takes up to two tokens per cycle, hands out one per pop.
// Depends on sbt_pkg.
module sbt_out_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  sbt_pkg::res_wr_t   res_wr,
	output logic               room,
	output logic               empty,
	input  logic               pop,
	output sbt_pkg::tok_word_t token
);
	import sbt_pkg::*;

	tok_word_t          mem_q [R_DEPTH];
	logic [R_IDX_W-1:0] wp_q;
	logic [R_IDX_W-1:0] rp_q;
	logic [R_CNT_W-1:0] cnt_q;
	logic [R_IDX_W-1:0] wp_next;
	logic               pop_ok;

	assign room = (cnt_q <= R_CNT_W'(R_DEPTH - 2));
	assign empty = (cnt_q == '0);
	assign pop_ok = pop && !empty;
	assign token = mem_q[rp_q];
	assign wp_next = wp_q + R_IDX_W'(1);

	always_ff @(posedge clk) begin
		if (res_wr.v0) begin
			mem_q[wp_q] <= res_wr.w0;
		end
		if (res_wr.v1) begin
			mem_q[wp_next] <= res_wr.w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + R_IDX_W'(res_wr.v0) + R_IDX_W'(res_wr.v1);
			if (pop_ok) begin
				rp_q <= rp_q + R_IDX_W'(1);
			end
			cnt_q <= cnt_q + R_CNT_W'(res_wr.v0) + R_CNT_W'(res_wr.v1) - R_CNT_W'(pop_ok);
		end
	end

endmodule

// File: hw/rtl/source_byte_tokenizer.sv
// Source byte tokenizer, top level: front classifier, word queue, scanner, result queue.
// Depends on sbt_pkg, sbt_front, sbt_queue, sbt_back, sbt_out_fifo and the defines header.
//
//   Channel   Handshake          Word
//   source    push / full        src_word_t (cmd, byte_value)
//   token     pop / empty        tok_word_t (kind, line, column, length, errors, last)
//
// One word is accepted per cycle while full is low; a result passes through the word queue and
// then the result queue, both registered, before it is on the token ports.
// The scanner takes one word per cycle while the result queue has two free slots, so a
// word that yields two tokens costs two pops at the output.
// Reset is asynchronous and active low; it empties both queues and restarts the source.
// A stall on the token side fills the result queue, then the word queue, then raises full.
`include "source_byte_tokenizer_defines.svh"

module source_byte_tokenizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  sbt_pkg::src_word_t source,
	output logic               empty,
	input  logic               pop,
	output sbt_pkg::tok_word_t token
);
	import sbt_pkg::*;

	cls_word_t cls_in;
	cls_word_t cls_out;
	logic      q_valid;
	logic      q_pop;
	logic      room;
	res_wr_t   res_wr;

	sbt_front u_front (
		.source (source),
		.cls    (cls_in)
	);

	sbt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.wr_data (cls_in),
		.valid   (q_valid),
		.pop     (q_pop),
		.rd_data (cls_out)
	);

	sbt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.c       (cls_out),
		.q_pop   (q_pop),
		.room    (room),
		.res_wr  (res_wr)
	);

	sbt_out_fifo u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.res_wr (res_wr),
		.room   (room),
		.empty  (empty),
		.pop    (pop),
		.token  (token)
	);

	`SBT_ASSERT_IMP(a_pair_order, clk, arst_n, res_wr.v1, res_wr.v0, "second token without first")
	`SBT_ASSERT_IMP(a_pair_last, clk, arst_n, res_wr.v1, !res_wr.w0.last_of_run && res_wr.w1.last_of_run, "last_of_run misplaced in token pair")
	`SBT_ASSERT_IMP(a_eof_shape, clk, arst_n, !empty && token.token_kind == KIND_EOF, token.byte_length == 16'd0 && token.last_of_run, "eof token malformed")
	`SBT_ASSERT_IMP(a_err_flag, clk, arst_n, !empty && token.token_kind != KIND_EOF, !token.errors_seen, "error flag on a non-eof token")
	`SBT_ASSERT_NEXT(a_no_overrun, clk, arst_n, q_pop, !(u_out.cnt_q > R_CNT_W'(R_DEPTH)), "result queue overrun")

endmodule

// File: tb/source_byte_tokenizer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for source_byte_tokenizer: a scripted run followed by random
// source text, checked against a token predictor in the bench or tokens given in the script.
// Depends on sbt_pkg and the source_byte_tokenizer RTL.
module source_byte_tokenizer_tb;
	import sbt_pkg::*;

	typedef enum logic [2:0] {
		SCAN_IDLE, SCAN_IDENT, SCAN_INT, SCAN_DOT, SCAN_FRAC, SCAN_CR
	} scan_phase_t;

	typedef struct packed {
		src_word_t word;
		logic      typed;
		tok_word_t want;
	} script_row_t;

	localparam int DIR_N = 25;
	localparam int RANDOM_ITEMS = 425;
	localparam tok_word_t UNTYPED = '0;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	src_word_t source = '0;
	logic      empty;
	logic      pop = 1'b0;
	tok_word_t token;

	logic      no_gaps = 1'b0;
	int        fail_count = 0;
	tok_word_t tokens_due [$];

	scan_phase_t sc_phase;
	logic [15:0] cur_line, cur_col, tok_line, tok_col, tok_len;
	logic [39:0] kw_buf;
	logic [1:0]  swallow_left;
	logic [4:0]  last_kept;
	logic        err_flag;
	tok_word_t   step_out [2];
	int          step_n;

	script_row_t script [DIR_N] = '{
		{CMD_BYTE, "(", 1'b1, KIND_PUNCT0, 16'd1, 16'd1, 16'd1, 1'b0, 1'b1},
		{CMD_BYTE, 8'h00, 1'b1, KIND_BADCHAR, 16'd1, 16'd2, 16'd1, 1'b0, 1'b1},
		{CMD_BYTE, 8'hF7, 1'b1, KIND_BADCHAR, 16'd1, 16'd3, 16'd1, 1'b0, 1'b1},
		{CMD_BYTE, 8'hFF, 1'b0, UNTYPED},
		{CMD_BYTE, "\n", 1'b0, UNTYPED},
		{CMD_BYTE, 8'h80, 1'b0, UNTYPED},
		{CMD_BYTE, "v", 1'b0, UNTYPED},
		{CMD_BYTE, 8'hBF, 1'b0, UNTYPED},
		{CMD_BYTE, "1", 1'b0, UNTYPED},
		{CMD_BYTE, " ", 1'b0, UNTYPED},
		{CMD_BYTE, "7", 1'b0, UNTYPED},
		{CMD_BYTE, ".", 1'b0, UNTYPED},
		{CMD_BYTE, ";", 1'b0, UNTYPED},
		{CMD_BYTE, ";", 1'b0, UNTYPED},
		{CMD_BYTE, "\r", 1'b0, UNTYPED},
		{CMD_BYTE, "x", 1'b0, UNTYPED},
		{CMD_BYTE, "\r", 1'b0, UNTYPED},
		{CMD_BYTE, "\n", 1'b0, UNTYPED},
		{CMD_BYTE, "\n", 1'b0, UNTYPED},
		{CMD_BYTE, "9", 1'b0, UNTYPED},
		{CMD_BYTE, ".", 1'b0, UNTYPED},
		{CMD_BYTE, "5", 1'b0, UNTYPED},
		{CMD_BYTE, "\t", 1'b0, UNTYPED},
		{CMD_END, 8'h00, 1'b0, UNTYPED},
		{CMD_END, 8'hFF, 1'b1, KIND_EOF, 16'd1, 16'd1, 16'd0, 1'b0, 1'b1}
	};

	source_byte_tokenizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.source (source),
		.empty  (empty),
		.pop    (pop),
		.token  (token)
	);

	function automatic logic [15:0] bump(input logic [15:0] v);
		return (&v) ? v : v + 16'd1;
	endfunction

	function automatic logic letter_byte(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic logic digit_byte(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic [7:0] pick_letter();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26) begin
			return 8'("a" + r);
		end
		if (r < 52) begin
			return 8'("A" + r - 26);
		end
		return BYTE_US;
	endfunction

	function automatic logic [7:0] pick_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 15);
		if (no_gaps || r < 9) begin
			return 0;
		end
		if (r < 15) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task clear_scanner();
		sc_phase = SCAN_IDLE;
		cur_line = 16'd1;
		cur_col = 16'd1;
		tok_line = 16'd1;
		tok_col = 16'd1;
		tok_len = 16'd0;
		kw_buf = '0;
		swallow_left = 2'd0;
		last_kept = KIND_NONE;
		err_flag = 1'b0;
	endtask

	task add_token(input logic [4:0] kind, input logic [15:0] ln, col, len, input logic errs);
		if (step_n < 2) begin
			step_out[step_n] = {kind, ln, col, len, errs, 1'b0};
			step_n++;
		end
	endtask

	task keep_token(input logic [4:0] kind, input logic [15:0] ln, col, len);
		if (kind == KIND_BADCHAR || kind == KIND_BADNUM) begin
			err_flag = 1'b1;
			add_token(kind, ln, col, len, 1'b0);
		end else if (!((kind == KIND_NEWLINE || kind == KIND_SEMI) && kind == last_kept)) begin
			last_kept = kind;
			add_token(kind, ln, col, len, 1'b0);
		end
	endtask

	function automatic logic [4:0] word_kind();
		if (tok_len == 16'd5 && kw_buf == KW_CONST) return KIND_CONST;
		if (tok_len == 16'd3 && kw_buf == KW_VAR) return KIND_VAR;
		if (tok_len == 16'd4 && kw_buf == KW_AUTO) return KIND_AUTO;
		if (tok_len == 16'd3 && kw_buf == KW_INT) return KIND_AUTO;
		if (tok_len == 16'd5 && kw_buf == KW_FLOAT) return KIND_AUTO;
		return KIND_IDENT;
	endfunction

	task close_token();
		logic [4:0] k;
		k = KIND_NONE;
		case (sc_phase)
			SCAN_IDENT: k = word_kind();
			SCAN_INT: k = KIND_INT;
			SCAN_DOT: k = KIND_BADNUM;
			SCAN_FRAC: k = KIND_FLOAT;
			SCAN_CR: k = KIND_NEWLINE;
			default: k = KIND_NONE;
		endcase
		if (k != KIND_NONE) begin
			keep_token(k, tok_line, tok_col, tok_len);
		end
		sc_phase = SCAN_IDLE;
	endtask

	task open_token(input scan_phase_t p);
		tok_line = cur_line;
		tok_col = cur_col;
		tok_len = 16'd1;
		kw_buf = '0;
		sc_phase = p;
	endtask

	task extend_token(input logic [7:0] b);
		if (tok_len < 16'd5) begin
			kw_buf[8*tok_len +: 8] = b;
		end
		tok_len = bump(tok_len);
		cur_col = bump(cur_col);
	endtask

	task scan_fresh(input logic [7:0] b);
		logic hit;
		hit = 1'b0;
		if (b == BYTE_SPACE || b == BYTE_TAB) begin
			cur_col = bump(cur_col);
		end else if (b == BYTE_LF) begin
			keep_token(KIND_NEWLINE, cur_line, cur_col, 16'd1);
			cur_line = bump(cur_line);
			cur_col = 16'd1;
		end else if (b == BYTE_CR) begin
			open_token(SCAN_CR);
			cur_line = bump(cur_line);
			cur_col = 16'd1;
		end else if (letter_byte(b) || b == BYTE_US) begin
			open_token(SCAN_IDENT);
			kw_buf[7:0] = b;
			cur_col = bump(cur_col);
		end else if (digit_byte(b)) begin
			open_token(SCAN_INT);
			cur_col = bump(cur_col);
		end else begin
			for (int i = 0; i < PUNCT_N; i++) begin
				if (PUNCT_CHARS[i] == b) begin
					keep_token(KIND_PUNCT0 + 5'(i), cur_line, cur_col, 16'd1);
					hit = 1'b1;
				end
			end
			if (!hit) begin
				keep_token(KIND_BADCHAR, cur_line, cur_col, 16'd1);
				if (b >= 8'hC0 && b < 8'hE0) begin
					swallow_left = 2'd1;
				end else if (b >= 8'hE0 && b < 8'hF0) begin
					swallow_left = 2'd2;
				end else if (b >= 8'hF0 && b < 8'hF8) begin
					swallow_left = 2'd3;
				end else begin
					swallow_left = 2'd0;
				end
			end
			cur_col = bump(cur_col);
		end
	endtask

	task tokenize_word(input src_word_t w);
		logic       taken;
		logic [7:0] b;
		step_n = 0;
		taken = 1'b0;
		b = w.byte_value;
		if (w.cmd == CMD_END) begin
			close_token();
			add_token(KIND_EOF, cur_line, cur_col, 16'd0, err_flag);
			clear_scanner();
		end else if (swallow_left > 2'd0) begin
			swallow_left--;
		end else begin
			case (sc_phase)
				SCAN_IDENT: begin
					if (letter_byte(b) || digit_byte(b) || b == BYTE_US || b[7:6] == 2'b10) begin
						extend_token(b);
						taken = 1'b1;
					end
				end
				SCAN_INT: begin
					if (digit_byte(b)) begin
						extend_token(b);
						taken = 1'b1;
					end else if (b == BYTE_DOT) begin
						extend_token(b);
						sc_phase = SCAN_DOT;
						taken = 1'b1;
					end
				end
				SCAN_DOT, SCAN_FRAC: begin
					if (digit_byte(b)) begin
						extend_token(b);
						sc_phase = SCAN_FRAC;
						taken = 1'b1;
					end
				end
				SCAN_CR: begin
					if (b == BYTE_LF) begin
						tok_len = 16'd2;
						close_token();
						taken = 1'b1;
					end
				end
				default: taken = 1'b0;
			endcase
			if (!taken) begin
				close_token();
				scan_fresh(b);
			end
		end
		if (step_n > 0) begin
			step_out[step_n-1].last_of_run = 1'b1;
		end
	endtask

	task send_word(input src_word_t w, input logic typed, input tok_word_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		source <= w;
		do @(posedge clk); while (full);
		tokenize_word(w);
		if (typed) begin
			tokens_due.push_back(want);
		end else begin
			for (int i = 0; i < step_n; i++) begin
				tokens_due.push_back(step_out[i]);
			end
		end
	endtask

	task wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (tokens_due.size() != 0) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		fail_count++;
		if (fail_count <= 40) begin
			$display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, want);
		end
	endtask

	task automatic check_token(input tok_word_t got);
		tok_word_t want;
		if (tokens_due.size() == 0) begin
			report_mismatch("unexpected word, token_kind", got.token_kind, 0);
			return;
		end
		want = tokens_due.pop_front();
		if (got.token_kind != want.token_kind)
			report_mismatch("token_kind", got.token_kind, want.token_kind);
		if (got.first_line != want.first_line)
			report_mismatch("first_line", got.first_line, want.first_line);
		if (got.start_column != want.start_column)
			report_mismatch("start_column", got.start_column, want.start_column);
		if (got.byte_length != want.byte_length)
			report_mismatch("byte_length", got.byte_length, want.byte_length);
		if (got.errors_seen != want.errors_seen)
			report_mismatch("errors_seen", got.errors_seen, want.errors_seen);
		if (got.last_of_run != want.last_of_run)
			report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int hold;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				check_token(token);
			end
			if (hold > 0) begin
				hold--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if (!no_gaps && $urandom_range(0, 5) == 0) begin
					hold = pick_gap();
				end
			end
		end
	end

	initial begin
		src_word_t  plan [$];
		string      kw_list [5];
		string      kw;
		logic [7:0] lead;
		int         sent, n, j, k;
		kw_list = '{"const", "var", "auto", "int", "float"};
		sent = 0;
		clear_scanner();
		@(posedge arst_n);
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			send_word(script[i].word, script[i].typed, script[i].want);
		end
		wait_drained();

		while (sent < RANDOM_ITEMS) begin
			plan.delete();
			case ($urandom_range(0, 19))
				0, 1: begin
					kw = kw_list[$urandom_range(0, 4)];
					for (j = 0; j < kw.len(); j++) plan.push_back({CMD_BYTE, kw[j]});
					if ($urandom_range(0, 3) == 0) plan.push_back({CMD_BYTE, pick_letter()});
				end
				2, 3: begin
					plan.push_back({CMD_BYTE, pick_letter()});
					n = $urandom_range(0, 7);
					for (j = 0; j < n; j++) begin
						case ($urandom_range(0, 3))
							0: plan.push_back({CMD_BYTE, pick_digit()});
							1: plan.push_back({CMD_BYTE, 8'($urandom_range(8'h80, 8'hBF))});
							default: plan.push_back({CMD_BYTE, pick_letter()});
						endcase
					end
				end
				4, 5: begin
					n = $urandom_range(1, 4);
					for (j = 0; j < n; j++) plan.push_back({CMD_BYTE, pick_digit()});
				end
				6, 7: begin
					n = $urandom_range(1, 3);
					for (j = 0; j < n; j++) plan.push_back({CMD_BYTE, pick_digit()});
					plan.push_back({CMD_BYTE, BYTE_DOT});
					n = $urandom_range(0, 3);
					for (j = 0; j < n; j++) plan.push_back({CMD_BYTE, pick_digit()});
				end
				8, 9, 10: plan.push_back({CMD_BYTE, PUNCT_CHARS[$urandom_range(0, PUNCT_N - 1)]});
				11, 12: begin
					n = $urandom_range(1, 3);
					for (j = 0; j < n; j++)
						plan.push_back({CMD_BYTE, $urandom_range(0, 1) ? BYTE_SPACE : BYTE_TAB});
				end
				13, 14: begin
					n = $urandom_range(1, 2);
					for (j = 0; j < n; j++) begin
						k = $urandom_range(0, 2);
						if (k != 0) plan.push_back({CMD_BYTE, BYTE_CR});
						if (k != 1) plan.push_back({CMD_BYTE, BYTE_LF});
					end
				end
				15: begin
					n = $urandom_range(1, 2);
					for (j = 0; j < n; j++) plan.push_back({CMD_BYTE, ";"});
				end
				16: begin
					lead = 8'($urandom_range(8'hC0, 8'hF7));
					plan.push_back({CMD_BYTE, lead});
					n = (lead < 8'hE0) ? 1 : (lead < 8'hF0) ? 2 : 3;
					if ($urandom_range(0, 3) == 0) n = $urandom_range(0, n);
					for (j = 0; j < n; j++) plan.push_back({CMD_BYTE, 8'($urandom)});
				end
				18: plan.push_back({CMD_END, 8'($urandom)});
				default: plan.push_back({CMD_BYTE, 8'($urandom)});
			endcase
			foreach (plan[i]) send_word(plan[i], 1'b0, UNTYPED);
			sent += plan.size();
			if (plan[plan.size()-1].cmd == CMD_END && $urandom_range(0, 1) == 0) begin
				wait_drained();
			end
			if ($urandom_range(0, 24) == 0) no_gaps = !no_gaps;
		end
		send_word({CMD_END, 8'h00}, 1'b0, UNTYPED);

		wait_drained();
		repeat (30) @(posedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
